>>> hw/rtl/stepper_step_pulse_generator_unit_assert.svh
// Assertion macros for the stepper pulse generator.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the including scope.
`ifndef STEPPER_STEP_PULSE_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_STEP_PULSE_GENERATOR_UNIT_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define STP_ASSERT_NOW(LBL, TRIG, PROP, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (TRIG) |-> (PROP)) \
        else $error(MSG);

// Condition holds in the cycle after the trigger.
`define STP_ASSERT_NEXT(LBL, TRIG, PROP, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (TRIG) |=> (PROP)) \
        else $error(MSG);

`endif

>>> hw/rtl/stp_pkg.sv
// Shared types, codes and constants of the stepper pulse generator.
// Used by the channel interfaces and the top level; depends on nothing.
package stp_pkg;

    // Field widths of the items and the configuration port.
    localparam int CMD_W        = 3;
    localparam int FIELD_W      = 24;
    localparam int SPEED_W      = 20;
    localparam int TICK_RATE_W  = 24;
    localparam int WAKE_W       = 16;
    localparam int ANGLE_STEP_W = 8;
    localparam int LEFT_W       = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    // Serial divider: dividend holds 2*|angle| + step angle, divisor holds the speed.
    localparam int DVD_W  = FIELD_W + 1;
    localparam int DVS_W  = SPEED_W + 1;
    localparam int QCNT_W = $clog2(DVD_W);

    // Default counter width of the period, tick and step counters.
    localparam int COUNT_WIDTH_DEF = 24;

    // Configuration values after reset.
    localparam logic [TICK_RATE_W-1:0]  TICK_RATE_RST   = 24'd1000000;
    localparam logic [WAKE_W-1:0]       WAKE_TICKS_RST  = 16'd1000;
    localparam logic [ANGLE_STEP_W-1:0] CENTIDEG_RST    = 8'd18;
    localparam logic [SPEED_W-1:0]      SINGLE_SPEED_RST = 20'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_MOVE_STEPS = 3'd1,
        CMD_MOVE_DEG   = 3'd2,
        CMD_SINGLE     = 3'd3,
        CMD_TOGGLE     = 3'd4,
        CMD_STOP       = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAKE,
        PH_STEP
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_ANG,
        S_DIV_PER,
        S_EMIT
    } t_fsm;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_RATE,
        CFG_WAKE_TICKS,
        CFG_CENTIDEG,
        CFG_SINGLE_SPEED
    } t_cfg_idx;

endpackage

>>> hw/rtl/stp_in_if.sv
// Input channel of the stepper pulse generator: commands and timer ticks.
// Depends on stp_pkg for the field widths.
interface stp_in_if;
    logic                                valid;
    logic                                ready;
    logic [stp_pkg::CMD_W-1:0]           command;
    logic signed [stp_pkg::FIELD_W-1:0]  step_count;
    logic signed [stp_pkg::FIELD_W-1:0]  angle_centideg;
    logic [stp_pkg::SPEED_W-1:0]         speed;

    modport source (
        output valid, command, step_count, angle_centideg, speed,
        input  ready
    );

    modport sink (
        input  valid, command, step_count, angle_centideg, speed,
        output ready
    );
endinterface

>>> hw/rtl/stp_out_if.sv
// Result channel of the stepper pulse generator: pin levels and status.
// Depends on stp_pkg for the field widths.
interface stp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          step_pin;
    logic                          dir_pin;
    logic                          enable_n;
    logic                          busy_res;
    logic                          done_res;
    logic [stp_pkg::LEFT_W-1:0]    steps_left;

    modport source (
        output valid, step_pin, dir_pin, enable_n, busy_res, done_res, steps_left,
        input  ready
    );

    modport sink (
        input  valid, step_pin, dir_pin, enable_n, busy_res, done_res, steps_left,
        output ready
    );
endinterface

>>> hw/rtl/stepper_step_pulse_generator_unit.sv
// Top level of the stepper step/direction pulse generator.
// Depends on stp_pkg, stp_in_if, stp_out_if and the assertion macro header.
//
// Usage:
// The input channel carries one item per command or timer tick (command 0 is
// one tick). The result channel returns exactly one item per input item with
// the step, direction and enable pin levels and the move status after it.
// The configuration port writes tick rate, wake delay, step angle and single step
// speed; the user must write it only while the block is idle, the block itself does
// not enforce this. Ticks, toggle, stop and ignored commands go from acceptance
// straight to the emit state. A move in steps or a single step runs the period
// division, a degree move the angle division and then, if it yields steps, the period
// division, on the shared bit-serial restoring divider (one quotient bit per cycle).
// One item is worked on at a time; the next is taken once the result of the
// current one sits in the output register.
// When the receiver stalls, the finished result waits in the output register,
// the next item is still accepted and processed, and its result waits until
// the register is free.
// Reset is synchronous: the driver is disabled, the phase is idle, the direction
// bit is zero, and the configuration returns to its default values.
`include "stepper_step_pulse_generator_unit_assert.svh"

module stepper_step_pulse_generator_unit #(
    parameter int COUNT_WIDTH = stp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    stp_in_if.sink                           i_in,
    stp_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [stp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int DVD_W  = stp_pkg::DVD_W;
    localparam int DVS_W  = stp_pkg::DVS_W;
    localparam int QCNT_W = stp_pkg::QCNT_W;

    // Saturate a quotient or magnitude to the counter width, zero becomes one.
    function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [DVD_W-1:0] v);
        logic [COUNT_WIDTH-1:0] res;
        if (v == '0) begin
            res = COUNT_WIDTH'(1);
        end else if ((v >> COUNT_WIDTH) != '0) begin
            res = '1;
        end else begin
            res = COUNT_WIDTH'(v);
        end
        return res;
    endfunction

    // Control and configuration.
    stp_pkg::t_fsm                          r_fsm, n_fsm;
    logic [stp_pkg::TICK_RATE_W-1:0]        r_tick_rate;
    logic [stp_pkg::WAKE_W-1:0]             r_wake_ticks;
    logic [stp_pkg::ANGLE_STEP_W-1:0]       r_cdeg;
    logic [stp_pkg::SPEED_W-1:0]            r_sspeed;

    // Move state.
    stp_pkg::t_phase                        r_phase;
    logic [COUNT_WIDTH-1:0]                 r_period;
    logic [COUNT_WIDTH-1:0]                 r_tick;
    logic [stp_pkg::WAKE_W-1:0]             r_wake;
    logic [COUNT_WIDTH-1:0]                 r_rem;
    logic                                   r_dir;
    logic                                   r_dis;
    logic                                   r_done;

    // Pending move operands.
    logic                                   r_neg;
    logic [DVD_W-1:0]                       r_mag;
    logic [stp_pkg::SPEED_W-1:0]            r_spd;

    // Serial divider.
    logic [DVD_W-1:0]                       r_dvd_q;
    logic [DVS_W-1:0]                       r_div_rem;
    logic [DVS_W-1:0]                       r_dvs;
    logic [QCNT_W-1:0]                      r_qcnt;

    // Output register.
    logic                                   r_ov;
    logic                                   r_o_pin;
    logic                                   r_o_dir;
    logic                                   r_o_dis;
    logic                                   r_o_busy;
    logic                                   r_o_done;
    logic [stp_pkg::LEFT_W-1:0]             r_o_left;

    // Combinational signals.
    logic                                   in_acc;
    logic                                   out_load;
    stp_pkg::t_cmd                          cmd;
    logic [stp_pkg::FIELD_W-1:0]            sc_u, ang_u, steps_abs, angle_abs;
    logic [stp_pkg::ANGLE_STEP_W-1:0]       c_eff;
    logic [DVD_W-1:0]                       ang_dvd;
    logic                                   go_ang, go_per;
    logic [stp_pkg::SPEED_W-1:0]            spd_sel;
    logic [DVS_W:0]                         rem_sh, div_diff;
    logic                                   div_ge;
    logic [DVS_W-1:0]                       n_div_rem;
    logic [DVD_W-1:0]                       n_div_quo;
    logic                                   div_last;
    logic [COUNT_WIDTH-1:0]                 tick_inc;
    logic [COUNT_WIDTH-1:0]                 rem_dec;
    logic [stp_pkg::WAKE_W-1:0]             wake_dec;

    assign in_acc = i_in.valid && i_in.ready;
    assign cmd    = stp_pkg::t_cmd'(i_in.command);

    // Sign and magnitude of the signed step count and angle.
    assign sc_u      = i_in.step_count;
    assign ang_u     = i_in.angle_centideg;
    assign steps_abs = sc_u[stp_pkg::FIELD_W-1] ? (~sc_u + 1'b1) : sc_u;
    assign angle_abs = ang_u[stp_pkg::FIELD_W-1] ? (~ang_u + 1'b1) : ang_u;

    // Rounding division for degree moves: (2*|angle| + c) / (2*c).
    assign c_eff   = (r_cdeg == '0) ? stp_pkg::ANGLE_STEP_W'(1) : r_cdeg;
    assign ang_dvd = {angle_abs, 1'b0} + DVD_W'(c_eff);

    // Which division a move command starts with, if any.
    assign spd_sel = (cmd == stp_pkg::CMD_SINGLE) ? r_sspeed : i_in.speed;
    assign go_ang  = (cmd == stp_pkg::CMD_MOVE_DEG) && (i_in.speed != '0)
                     && (r_phase == stp_pkg::PH_IDLE);
    assign go_per  = (r_phase == stp_pkg::PH_IDLE) &&
                     (((cmd == stp_pkg::CMD_MOVE_STEPS) && (i_in.speed != '0)
                       && (steps_abs != '0)) ||
                      ((cmd == stp_pkg::CMD_SINGLE) && (r_sspeed != '0)));

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    assign rem_sh    = {r_div_rem, r_dvd_q[DVD_W-1]};
    assign div_diff  = rem_sh - {1'b0, r_dvs};
    assign div_ge    = !div_diff[DVS_W];
    assign n_div_rem = div_ge ? div_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    assign n_div_quo = {r_dvd_q[DVD_W-2:0], div_ge};
    assign div_last  = (r_qcnt == '0);

    // Tick arithmetic of the wake and step phases.
    assign tick_inc = r_tick + 1'b1;
    assign rem_dec  = (r_rem != '0) ? (r_rem - 1'b1) : r_rem;
    assign wake_dec = (r_wake != '0) ? (r_wake - 1'b1) : r_wake;

    // Sequencer next state.
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            stp_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (go_ang) begin
                        n_fsm = stp_pkg::S_DIV_ANG;
                    end else if (go_per) begin
                        n_fsm = stp_pkg::S_DIV_PER;
                    end else begin
                        n_fsm = stp_pkg::S_EMIT;
                    end
                end
            end
            stp_pkg::S_DIV_ANG: begin
                if (div_last) begin
                    n_fsm = (n_div_quo == '0) ? stp_pkg::S_EMIT : stp_pkg::S_DIV_PER;
                end
            end
            stp_pkg::S_DIV_PER: begin
                if (div_last) begin
                    n_fsm = stp_pkg::S_EMIT;
                end
            end
            stp_pkg::S_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_fsm = stp_pkg::S_IDLE;
                end
            end
            default: n_fsm = stp_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_in.ready = (r_fsm == stp_pkg::S_IDLE);
        out_load   = (r_fsm == stp_pkg::S_EMIT) && (!r_ov || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= stp_pkg::S_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate  <= stp_pkg::TICK_RATE_RST;
            r_wake_ticks <= stp_pkg::WAKE_TICKS_RST;
            r_cdeg       <= stp_pkg::CENTIDEG_RST;
            r_sspeed     <= stp_pkg::SINGLE_SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (stp_pkg::t_cfg_idx'(i_cfg_idx))
                stp_pkg::CFG_TICK_RATE:
                    r_tick_rate <= i_cfg_wdata[stp_pkg::TICK_RATE_W-1:0];
                stp_pkg::CFG_WAKE_TICKS:
                    r_wake_ticks <= i_cfg_wdata[stp_pkg::WAKE_W-1:0];
                stp_pkg::CFG_CENTIDEG:
                    r_cdeg <= i_cfg_wdata[stp_pkg::ANGLE_STEP_W-1:0];
                stp_pkg::CFG_SINGLE_SPEED:
                    r_sspeed <= i_cfg_wdata[stp_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Move operands, latched whenever an item is taken; the step count of a degree move comes from the angle division.
    always_ff @(posedge i_clk) begin
        if ((r_fsm == stp_pkg::S_IDLE) && in_acc) begin
            r_spd <= i_in.speed;
            case (cmd)
                stp_pkg::CMD_MOVE_STEPS: begin
                    r_neg <= sc_u[stp_pkg::FIELD_W-1];
                    r_mag <= DVD_W'(steps_abs);
                end
                stp_pkg::CMD_MOVE_DEG: begin
                    r_neg <= ang_u[stp_pkg::FIELD_W-1];
                    r_mag <= '0;
                end
                default: begin
                    r_neg <= 1'b0;
                    r_mag <= DVD_W'(1);
                end
            endcase
        end else if ((r_fsm == stp_pkg::S_DIV_ANG) && div_last) begin
            r_mag <= n_div_quo;
        end
    end

    // Serial divider: loads, then one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0;
        end else if ((r_fsm == stp_pkg::S_IDLE) && in_acc && go_ang) begin
            r_dvd_q   <= ang_dvd;
            r_dvs     <= DVS_W'({c_eff, 1'b0});
            r_div_rem <= '0;
            r_qcnt    <= QCNT_W'(DVD_W - 1);
        end else if ((r_fsm == stp_pkg::S_IDLE) && in_acc && go_per) begin
            r_dvd_q   <= DVD_W'(r_tick_rate);
            r_dvs     <= DVS_W'(spd_sel);
            r_div_rem <= '0;
            r_qcnt    <= QCNT_W'(DVD_W - 1);
        end else if ((r_fsm == stp_pkg::S_DIV_ANG) && div_last) begin
            r_dvd_q   <= DVD_W'(r_tick_rate);
            r_dvs     <= DVS_W'(r_spd);
            r_div_rem <= '0;
            r_qcnt    <= QCNT_W'(DVD_W - 1);
        end else if ((r_fsm == stp_pkg::S_DIV_ANG) || (r_fsm == stp_pkg::S_DIV_PER)) begin
            r_dvd_q   <= n_div_quo;
            r_div_rem <= n_div_rem;
            r_qcnt    <= r_qcnt - 1'b1;
        end
    end

    // Move state: ticks, toggle and stop act on acceptance, a move starts
    // once its period is known.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= stp_pkg::PH_IDLE;
            r_period <= '0;
            r_tick   <= '0;
            r_wake   <= '0;
            r_rem    <= '0;
            r_dir    <= 1'b0;
            r_dis    <= 1'b1;
            r_done   <= 1'b0;
        end else if ((r_fsm == stp_pkg::S_IDLE) && in_acc) begin
            r_done <= 1'b0;
            case (cmd)
                stp_pkg::CMD_TICK: begin
                    if (r_phase == stp_pkg::PH_WAKE) begin
                        r_wake <= wake_dec;
                        if (wake_dec == '0) begin
                            r_phase <= stp_pkg::PH_STEP;
                            r_tick  <= '0;
                        end
                    end else if (r_phase == stp_pkg::PH_STEP) begin
                        if (tick_inc >= r_period) begin
                            r_tick <= '0;
                            r_rem  <= rem_dec;
                            if (rem_dec == '0) begin
                                r_phase <= stp_pkg::PH_IDLE;
                                r_dis   <= 1'b1;
                                r_done  <= 1'b1;
                            end
                        end else begin
                            r_tick <= tick_inc;
                        end
                    end
                end
                stp_pkg::CMD_TOGGLE: begin
                    r_dir <= !r_dir;
                end
                stp_pkg::CMD_STOP: begin
                    r_phase <= stp_pkg::PH_IDLE;
                    r_dis   <= 1'b1;
                    r_rem   <= '0;
                    r_tick  <= '0;
                    r_wake  <= '0;
                end
                default: ;
            endcase
        end else if ((r_fsm == stp_pkg::S_DIV_PER) && div_last) begin
            r_dir    <= r_neg;
            r_period <= sat_cnt(n_div_quo);
            r_rem    <= sat_cnt(r_mag);
            r_tick   <= '0;
            r_dis    <= 1'b0;
            r_wake   <= r_wake_ticks;
            r_phase  <= (r_wake_ticks == '0) ? stp_pkg::PH_STEP : stp_pkg::PH_WAKE;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    // Output register payload, taken from the state after the item.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_pin  <= (r_phase == stp_pkg::PH_STEP) && (r_tick < (r_period >> 1));
            r_o_dir  <= r_dir;
            r_o_dis  <= r_dis;
            r_o_busy <= (r_phase != stp_pkg::PH_IDLE);
            r_o_done <= r_done;
            r_o_left <= (r_phase != stp_pkg::PH_IDLE) ? stp_pkg::LEFT_W'(r_rem) : '0;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.step_pin   = r_o_pin;
    assign o_out.dir_pin    = r_o_dir;
    assign o_out.enable_n   = r_o_dis;
    assign o_out.busy_res   = r_o_busy;
    assign o_out.done_res   = r_o_done;
    assign o_out.steps_left = r_o_left;

    // The driver is enabled exactly while a move is in progress.
    `STP_ASSERT_NOW(a_enable_tracks_phase, 1'b1, (r_phase == stp_pkg::PH_IDLE) == r_dis, "driver enable out of step with phase")
    // A move in progress always has steps left to issue.
    `STP_ASSERT_NOW(a_busy_has_steps, r_phase != stp_pkg::PH_IDLE, r_rem != '0, "busy with no steps left")
    // While stepping, the tick counter stays inside a nonzero period.
    `STP_ASSERT_NOW(a_tick_in_period, r_phase == stp_pkg::PH_STEP, (r_period != '0) && (r_tick < r_period), "tick count outside step period")
    // A stop item leaves the block idle.
    `STP_ASSERT_NEXT(a_stop_goes_idle, i_in.valid && i_in.ready && (i_in.command == stp_pkg::CMD_STOP), r_phase == stp_pkg::PH_IDLE, "stop did not end the move")

endmodule
